// ===== src/text_pattern_match_scanner_top_assert.svh =====
// Assertion macros for the text pattern match scanner checker.
// Used by tpms_checker.sv; needs clk and rst_n in the including scope.
`ifndef TEXT_PATTERN_MATCH_SCANNER_TOP_ASSERT_SVH
`define TEXT_PATTERN_MATCH_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TPMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpms assertion failed");

// next-cycle implication, disabled during reset
`define TPMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpms assertion failed");

`endif

// ===== src/tpms_pkg.sv =====
// Shared types, constants and byte helpers for the text pattern match scanner.
// No dependencies.
`default_nettype none
package tpms_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int COL_BITS    = 16;
  localparam int LINE_BITS   = 20;
  localparam int NUM_BITS    = 20;
  localparam int COUNT_BITS  = COL_BITS + 1;
  localparam int LEN_BITS    = 5;
  localparam int PAT_BYTES   = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int SEL_BITS    = $clog2(MAX_PATTERN);
  localparam logic [7:0] UNDERSCORE = 8'h5F;

  typedef logic [7:0] byte_t;
  typedef logic [MAX_PATTERN:0][7:0]   win_t;
  typedef logic [MAX_PATTERN-1:0][7:0] pat_t;

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_EOL     = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_IGNORE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_HI     = 3'd1,
    CFG_PAT_LEN    = 3'd2,
    CFG_CASE_SENS  = 3'd3,
    CFG_WHOLE_WORD = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LINE_BITS-1:0] line;
    logic [COL_BITS-1:0]  column;
    logic [NUM_BITS-1:0]  number;
  } res_t;

  function automatic byte_t fold_byte(input byte_t c, input logic case_sens);
    byte_t r;
    r = c;
    if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic word_char(input byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == UNDERSCORE);
  endfunction

endpackage
`default_nettype wire

// ===== src/tpms_if.sv =====
// Valid/ready channel interfaces for the scanner's text input and match output.
// Depends on tpms_pkg.
`default_nettype none
interface tpms_in_if
  import tpms_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] character;

  modport source (output valid, output kind, output character, input ready);
  modport sink   (input valid, input kind, input character, output ready);
endinterface

interface tpms_out_if
  import tpms_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [LINE_BITS-1:0] match_line;
  logic [COL_BITS-1:0]  match_column;
  logic [NUM_BITS-1:0]  match_number;

  modport source (output valid, output match_line, output match_column,
                  output match_number, input ready);
  modport sink   (input valid, input match_line, input match_column,
                  input match_number, output ready);
endinterface
`default_nettype wire

// ===== src/tpms_pat_align.sv =====
// Registers the pattern right-aligned to the text window, folded, with masks.
// Depends on tpms_pkg.
`default_nettype none
module tpms_pat_align
  import tpms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CFG_DATA_W-1:0] pat_lo,
  input  wire logic [CFG_DATA_W-1:0] pat_hi,
  input  wire logic [LEN_BITS-1:0]   pat_len,
  input  wire logic                  case_sens,
  output pat_t                       aligned_r,
  output logic [MAX_PATTERN-1:0]     mask_r,
  output logic [MAX_PATTERN:0]       border_r,
  output logic                       len_ok_r
);

  logic [PAT_BYTES*8-1:0]   pat_all;
  pat_t                     aligned_nxt;
  logic [MAX_PATTERN-1:0]   mask_nxt;
  logic [MAX_PATTERN:0]     border_nxt;
  logic                     len_ok_nxt;

  assign pat_all = {pat_hi, pat_lo};

  // window tap k holds pattern byte len-1-k
  always_comb begin
    logic [SEL_BITS-1:0] sel;
    sel = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      sel = SEL_BITS'(pat_len - LEN_BITS'(1) - LEN_BITS'(k));
      mask_nxt[k] = (LEN_BITS'(k) < pat_len);
      if (int'(sel) < PAT_BYTES) begin
        aligned_nxt[k] = fold_byte(pat_all[8*sel +: 8], case_sens);
      end else begin
        aligned_nxt[k] = fold_byte(8'h00, case_sens);
      end
    end
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      border_nxt[k] = (pat_len == LEN_BITS'(k));
    end
    len_ok_nxt = (pat_len != '0) && (pat_len <= LEN_BITS'(MAX_PATTERN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      border_r <= '0;
      len_ok_r <= 1'b0;
    end else begin
      mask_r   <= mask_nxt;
      border_r <= border_nxt;
      len_ok_r <= len_ok_nxt;
    end
    aligned_r <= aligned_nxt;
  end

endmodule
`default_nettype wire

// ===== src/tpms_window_cmp.sv =====
// Compares the low MAX_PATTERN window taps against the aligned pattern in
// parallel and picks the byte just before the match. Depends on tpms_pkg.
`default_nettype none
module tpms_window_cmp
  import tpms_pkg::*;
(
  input  wire win_t                    win,
  input  wire pat_t                    aligned,
  input  wire logic [MAX_PATTERN-1:0]  mask,
  input  wire logic [MAX_PATTERN:0]    border,
  input  wire logic                    case_sens,
  output logic                         all_eq,
  output logic                         border_word
);

  logic [MAX_PATTERN-1:0] eq;
  byte_t                  border_byte;

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      eq[k] = (fold_byte(win[k], case_sens) == aligned[k]) || !mask[k];
    end
    border_byte = '0;
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      border_byte = border_byte | (win[k] & {8{border[k]}});
    end
  end

  assign all_eq      = &eq;
  assign border_word = word_char(border_byte);

endmodule
`default_nettype wire

// ===== src/tpms_out_buf.sv =====
// Output register with a one-entry skid stage for match results.
// Depends on tpms_pkg and tpms_out_if.
`default_nettype none
module tpms_out_buf
  import tpms_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire res_t   push_data,
  output logic        full,
  tpms_out_if.source  out_ch
);

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;

  // push never arrives while the skid stage is occupied
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign full                = skid_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.match_line   = out_data_r.line;
  assign out_ch.match_column = out_data_r.column;
  assign out_ch.match_number = out_data_r.number;

endmodule
`default_nettype wire

// ===== src/text_pattern_match_scanner_top.sv =====
// Top level of the streaming text pattern match scanner: config registers,
// line state and match resolution. Depends on tpms_pkg, the interfaces,
// tpms_pat_align, tpms_window_cmp and tpms_out_buf.
//
//   channel | port group | direction | carries
//   --------+------------+-----------+-------------------------------------
//   input   | in_ch      | sink      | kind, character
//   result  | out_ch     | source    | match_line, match_column, match_number
//   config  | cfg_*      | write     | pattern_low/high/length, flags
//
// One item per cycle: the window compare and state update sit between the
// state registers and the result register, so an item is taken every cycle
// while in_ch.ready is high. Results are registered in tpms_out_buf; with
// whole-word mode the verdict on a match comes with the following item.
// Synchronous active-low reset clears all scan state and the config.
// in_ch.ready drops while the skid stage is full and for one cycle after a
// config write, while the aligned pattern registers settle.
`default_nettype none
module text_pattern_match_scanner_top
  import tpms_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tpms_in_if.sink                    in_ch,
  tpms_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [CFG_DATA_W-1:0] pat_lo_r, pat_hi_r;
  logic [LEN_BITS-1:0]   pat_len_r;
  logic                  case_sens_r, whole_word_r, cfg_settle_r;

  // scan state
  win_t                  win_r, win_nxt;
  logic [COUNT_BITS-1:0] bytes_r, bytes_nxt;
  logic [LINE_BITS-1:0]  line_r, line_nxt;
  logic                  pend_r, pend_nxt;
  logic [COL_BITS-1:0]   pend_col_r, pend_col_nxt;
  logic [NUM_BITS-1:0]   num_r, num_nxt;

  pat_t                  aligned;
  logic [MAX_PATTERN-1:0] mask;
  logic [MAX_PATTERN:0]  border;
  logic                  len_ok, all_eq, border_word, skid_full;

  logic                  in_fire, push;
  kind_t                 kind;
  byte_t                 ch;
  win_t                  win_shift;
  logic [COUNT_BITS-1:0] bytes_inc, col_diff;
  logic [COL_BITS-1:0]   column;
  logic                  hit, pend_emit;
  res_t                  push_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r     <= '0;
      pat_hi_r     <= '0;
      pat_len_r    <= '0;
      case_sens_r  <= 1'b0;
      whole_word_r <= 1'b0;
      cfg_settle_r <= 1'b0;
    end else begin
      cfg_settle_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PAT_LO:     pat_lo_r     <= cfg_wdata;
          CFG_PAT_HI:     pat_hi_r     <= cfg_wdata;
          CFG_PAT_LEN:    pat_len_r    <= cfg_wdata[LEN_BITS-1:0];
          CFG_CASE_SENS:  case_sens_r  <= cfg_wdata[0];
          CFG_WHOLE_WORD: whole_word_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  tpms_pat_align u_align (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat_lo    (pat_lo_r),
    .pat_hi    (pat_hi_r),
    .pat_len   (pat_len_r),
    .case_sens (case_sens_r),
    .aligned_r (aligned),
    .mask_r    (mask),
    .border_r  (border),
    .len_ok_r  (len_ok)
  );

  assign in_ch.ready = !skid_full && !cfg_settle_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign kind        = kind_t'(in_ch.kind);
  assign ch          = in_ch.character;

  always_comb begin
    win_shift = {win_r[MAX_PATTERN-1:0], ch};
  end

  assign bytes_inc = (bytes_r != COUNT_MAX) ? bytes_r + COUNT_BITS'(1) : bytes_r;

  tpms_window_cmp u_cmp (
    .win         (win_shift),
    .aligned     (aligned),
    .mask        (mask),
    .border      (border),
    .case_sens   (case_sens_r),
    .all_eq      (all_eq),
    .border_word (border_word)
  );

  always_comb begin
    hit = len_ok && all_eq && (bytes_inc >= COUNT_BITS'(pat_len_r)) &&
          !(whole_word_r && (bytes_inc > COUNT_BITS'(pat_len_r)) && border_word);
    col_diff = bytes_inc - COUNT_BITS'(pat_len_r);
    column   = col_diff[COUNT_BITS-1] ? '1 : col_diff[COL_BITS-1:0];
    // a pending match survives unless whole-word sees a word byte next
    pend_emit = pend_r &&
                !(whole_word_r && (kind == KIND_TEXT) && word_char(ch));
  end

  always_comb begin
    win_nxt      = win_r;
    bytes_nxt    = bytes_r;
    line_nxt     = line_r;
    pend_nxt     = pend_r;
    pend_col_nxt = pend_col_r;
    num_nxt      = num_r;
    push         = 1'b0;
    push_data    = '{line: line_r, column: pend_col_r, number: num_r};
    if (num_r != '1) begin
      push_data.number = num_r + NUM_BITS'(1);
    end
    if (in_fire && kind != KIND_IGNORE) begin
      pend_nxt = 1'b0;
      if (pend_emit) begin
        push    = 1'b1;
        num_nxt = push_data.number;
      end
      case (kind)
        KIND_EOL: begin
          win_nxt   = '0;
          bytes_nxt = '0;
          if (line_r != '1) begin
            line_nxt = line_r + LINE_BITS'(1);
          end
        end
        KIND_RESTART: begin
          win_nxt      = '0;
          bytes_nxt    = '0;
          line_nxt     = '0;
          num_nxt      = '0;
          pend_col_nxt = '0;
        end
        default: begin
          win_nxt   = win_shift;
          bytes_nxt = bytes_inc;
          if (hit) begin
            if (whole_word_r || pend_emit) begin
              pend_nxt     = 1'b1;
              pend_col_nxt = column;
            end else begin
              push             = 1'b1;
              push_data.column = column;
              num_nxt          = push_data.number;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      bytes_r    <= '0;
      line_r     <= '0;
      pend_r     <= 1'b0;
      pend_col_r <= '0;
      num_r      <= '0;
    end else begin
      win_r      <= win_nxt;
      bytes_r    <= bytes_nxt;
      line_r     <= line_nxt;
      pend_r     <= pend_nxt;
      pend_col_r <= pend_col_nxt;
      num_r      <= num_nxt;
    end
  end

  tpms_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (skid_full),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== src/tpms_checker.sv =====
// Port-level checker for the text pattern match scanner, bound to the top.
// Depends on tpms_pkg and text_pattern_match_scanner_top_assert.svh.
`default_nettype none
`include "text_pattern_match_scanner_top_assert.svh"
module tpms_checker
  import tpms_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [NUM_BITS-1:0] out_match_number,
  input wire logic                cfg_we
);

  // a stalled result holds
  `TPMS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_match_number))
  // input is held off in the cycle after a write while the aligned pattern settles
  `TPMS_ASSERT_NXT(a_cfg_settle, cfg_we, !in_ready)
  // a fresh result always follows an accepted item
  `TPMS_ASSERT_IMP(a_out_cause, $rose(out_valid), $past(in_valid && in_ready))
  // match ordinals start at one
  `TPMS_ASSERT_IMP(a_num_nonzero, out_valid, out_match_number != '0)

endmodule

bind text_pattern_match_scanner_top tpms_checker u_tpms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_match_number (out_ch.match_number),
  .cfg_we           (cfg_we)
);
`default_nettype wire

// ===== dv/tb_text_pattern_match_scanner_top.sv =====
`timescale 1ns / 100ps
// Testbench for text_pattern_match_scanner_top: directed and random text streams
// are scanned by an in-bench predictor and every match item is checked field by field.
// Depends on tpms_pkg, tpms_if.sv and the scanner RTL.

module tb_text_pattern_match_scanner_top;
  import tpms_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_GAP       = 6;
  localparam int PHASE_ITEMS   = 130;
  localparam int LONG_LINE     = 60;
  localparam int LONG_PERIOD   = 11;
  localparam int LEN_TOP       = (1 << LEN_BITS) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_WHOLE_WORD + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;
  // small alphabet so random text keeps hitting random patterns
  localparam logic [63:0] SOUP = "abAB_0 .";

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tpms_in_if  in_ch ();
  tpms_out_if out_ch ();

  text_pattern_match_scanner_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // scan predictor: configuration copy and line state
  logic [CFG_DATA_W-1:0] pat_lo  = '0;
  logic [CFG_DATA_W-1:0] pat_hi  = '0;
  logic [LEN_BITS-1:0]   pat_len = '0;
  logic                  exact   = 1'b0;
  logic                  whole   = 1'b0;

  logic [7:0]            win [0:MAX_PATTERN] = '{default: '0};
  logic [COUNT_BITS-1:0] line_bytes = '0;
  logic [LINE_BITS-1:0]  line_no    = '0;
  logic [NUM_BITS-1:0]   match_cnt  = '0;
  logic                  pend_ok    = 1'b0;
  logic [COL_BITS-1:0]   pend_col   = '0;

  res_t match_q [$];
  int   err_count = 0;
  bit   in_steady = 1'b0;
  bit   out_steady = 1'b0;

  function automatic byte_t fold_case(input byte_t c);
    if (!exact && c >= "A" && c <= "Z") begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic bit is_word(input byte_t c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || (c == "_");
  endfunction

  function automatic byte_t pat_byte(input int i);
    if (i < 8) begin
      return pat_lo[8*i +: 8];
    end
    return pat_hi[8*(i-8) +: 8];
  endfunction

  function automatic res_t next_match(input logic [COL_BITS-1:0] col);
    res_t r;
    if (match_cnt != '1) begin
      match_cnt++;
    end
    r.line   = line_no;
    r.column = col;
    r.number = match_cnt;
    return r;
  endfunction

  function automatic bit scan_item(input kind_t k, input byte_t c, output res_t r);
    bit                    got;
    bit                    hit;
    int                    len;
    logic [COUNT_BITS-1:0] start;
    logic [COL_BITS-1:0]   col;
    got = 1'b0;
    r   = '0;
    if (k == KIND_IGNORE) begin
      return 1'b0;
    end
    // any non-ignored item settles a held match; only a word byte under whole-word drops it
    if (pend_ok) begin
      pend_ok = 1'b0;
      if (!(whole && k == KIND_TEXT && is_word(c))) begin
        r   = next_match(pend_col);
        got = 1'b1;
      end
    end
    if (k == KIND_EOL || k == KIND_RESTART) begin
      line_bytes = '0;
      foreach (win[i]) win[i] = '0;
      if (k == KIND_EOL) begin
        if (line_no != '1) begin
          line_no++;
        end
      end else begin
        line_no   = '0;
        match_cnt = '0;
        pend_col  = '0;
      end
      return got;
    end
    for (int i = MAX_PATTERN; i > 0; i--) win[i] = win[i-1];
    win[0] = c;
    if (line_bytes != '1) begin
      line_bytes++;
    end
    len = int'(pat_len);
    hit = len != 0 && len <= MAX_PATTERN && line_bytes >= len;
    for (int i = 0; hit && i < len; i++) begin
      if (fold_case(win[len-1-i]) != fold_case(pat_byte(i))) begin
        hit = 1'b0;
      end
    end
    if (hit && whole && line_bytes > len && is_word(win[len])) begin
      hit = 1'b0;
    end
    if (!hit) begin
      return got;
    end
    start = COUNT_BITS'(line_bytes - len);
    col   = start[COUNT_BITS-1] ? '1 : start[COL_BITS-1:0];
    // hold the match if whole-word needs the next byte or this item already reported
    if (whole || got) begin
      pend_ok  = 1'b1;
      pend_col = col;
    end else begin
      r   = next_match(col);
      got = 1'b1;
    end
    return got;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= 100) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  task automatic send_item(input kind_t k, input byte_t c);
    int   gap;
    res_t r;
    gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= k;
    in_ch.character <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (scan_item(k, c, r)) begin
      match_q = {match_q, r};
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_TEXT, s[i]);
  endtask

  // drop valid and hold until every predicted match has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    case (idx)
      CFG_PAT_LO:     pat_lo  = d;
      CFG_PAT_HI:     pat_hi  = d;
      CFG_PAT_LEN:    pat_len = d[LEN_BITS-1:0];
      CFG_CASE_SENS:  exact   = d[0];
      CFG_WHOLE_WORD: whole   = d[0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                              input logic [LEN_BITS-1:0] len, input logic cs, input logic ww);
    logic [CFG_DATA_W-1:0] noise;
    noise = {$urandom, $urandom};
    cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)), noise);
    cfg_write(CFG_PAT_LO, lo);
    cfg_write(CFG_PAT_HI, hi);
    // upper bits of the narrow registers carry noise and must be ignored
    cfg_write(CFG_PAT_LEN, {noise[CFG_DATA_W-1:LEN_BITS], len});
    cfg_write(CFG_CASE_SENS, {noise[CFG_DATA_W-1:1], cs});
    cfg_write(CFG_WHOLE_WORD, {noise[CFG_DATA_W-1:1], ww});
    cfg_we <= 1'b0;
  endtask

  function automatic byte_t soup_char();
    if ($urandom_range(0, 4) == 0) begin
      return byte_t'($urandom);
    end
    return SOUP[8*$urandom_range(0, 7) +: 8];
  endfunction

  function automatic byte_t mix_case(input byte_t c);
    if ($urandom_range(0, 1) == 1 && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // reset configuration has zero length: nothing may match, not even zero bytes
  task automatic test_empty_pattern();
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
  endtask

  task automatic test_overlap();
    wait_drained();
    load_pattern(64'h6161, '0, LEN_BITS'(2), 1'b1, 1'b0);  // "aa", exact
    send_text("aaa");
    send_item(KIND_IGNORE, "a");
    send_item(KIND_EOL, 8'hA5);
  endtask

  task automatic test_whole_word();
    wait_drained();
    load_pattern(64'h4241, '0, LEN_BITS'(2), 1'b0, 1'b1);  // "AB", folded
    // reported by '.', dropped by '9', rejected after '_'
    send_text("aB.ab9_ab");
    send_item(KIND_EOL, 8'h00);
  endtask

  task automatic test_two_at_once();
    wait_drained();
    load_pattern(64'h2E2E, '0, LEN_BITS'(2), 1'b1, 1'b1);  // ".."
    send_text("..");
    // the held match survives a switch to plain mode and still comes one item late
    wait_drained();
    load_pattern(64'h2E2E, '0, LEN_BITS'(2), 1'b1, 1'b0);
    send_text("..");
    send_item(KIND_RESTART, 8'h5A);
  endtask

  task automatic test_extremes();
    wait_drained();
    load_pattern(64'hFF00, '1, LEN_BITS'(2), 1'b0, 1'b0);
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    wait_drained();
    load_pattern('1, '1, LEN_BITS'(LEN_TOP), 1'b1, 1'b1);  // overlong: no match
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_TEXT, 8'hFF);
    send_item(KIND_EOL, 8'hFF);
  endtask

  task automatic test_random_text();
    int                     lengths [8];
    logic [8*PAT_BYTES-1:0] pat;
    int                     len;
    int                     sent;
    int                     line_len;
    lengths = '{1, 3, 16, 2, 0, 5, 17, 4};
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      for (int i = 0; i < PAT_BYTES; i++) pat[8*i +: 8] = soup_char();
      len = lengths[p];
      if (len > MAX_PATTERN) begin
        len = $urandom_range(MAX_PATTERN + 1, LEN_TOP);
      end
      load_pattern(pat[63:0], pat[127:64], len[LEN_BITS-1:0],
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        in_steady  = ($urandom_range(0, 3) == 0);
        out_steady = ($urandom_range(0, 3) == 0);
        line_len   = $urandom_range(0, 24);
        for (int j = 0; j < line_len; j++) begin
          if (len > 0 && len <= MAX_PATTERN && $urandom_range(0, 4) == 0) begin
            for (int i = 0; i < len; i++) send_item(KIND_TEXT, mix_case(pat[8*i +: 8]));
            sent += len;
          end else if ($urandom_range(0, 30) == 0) begin
            send_item(KIND_IGNORE, byte_t'($urandom));
          end else begin
            send_item(KIND_TEXT, soup_char());
            sent++;
          end
        end
        case ($urandom_range(0, 19))
          0: send_item(KIND_RESTART, byte_t'($urandom));
          1: begin
            wait_drained();
            send_item(KIND_EOL, byte_t'($urandom));
          end
          default: send_item(KIND_EOL, byte_t'($urandom));
        endcase
        sent++;
      end
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
  endtask

  // one long unbroken line with the pattern recurring at a fixed period
  task automatic test_long_line();
    int ph;
    wait_drained();
    load_pattern(64'h7A7978, '0, LEN_BITS'(3), 1'b1, 1'b0);  // "xyz"
    in_steady = 1'b1;
    send_item(KIND_RESTART, 8'h00);
    for (int i = 0; i < LONG_LINE; i++) begin
      ph = i % LONG_PERIOD;
      send_item(KIND_TEXT, (ph < 3) ? pat_lo[8*ph +: 8] : 8'h61);
    end
    send_item(KIND_EOL, 8'h00);
    in_steady = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin : match_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (match_q.size() == 0) begin
        report_mismatch("unexpected match, line", out_ch.match_line, 0);
      end else begin
        want = match_q.pop_front();
        if (out_ch.match_line !== want.line) begin
          report_mismatch("match_line", out_ch.match_line, want.line);
        end
        if (out_ch.match_column !== want.column) begin
          report_mismatch("match_column", out_ch.match_column, want.column);
        end
        if (out_ch.match_number !== want.number) begin
          report_mismatch("match_number", out_ch.match_number, want.number);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TEXT;
    in_ch.character = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pattern();
    test_overlap();
    test_whole_word();
    test_two_at_once();
    test_extremes();
    test_random_text();
    test_long_line();
    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tpms_pkg.sv
src/tpms_if.sv
src/tpms_pat_align.sv
src/tpms_window_cmp.sv
src/tpms_out_buf.sv
src/text_pattern_match_scanner_top.sv
src/tpms_checker.sv
dv/tb_text_pattern_match_scanner_top.sv
